// File: sv/bpc_pkg.sv
// shared types and constants for the button press classifier
package bpc_pkg;

    // widths fixed by the scan and result words
    localparam int TICK_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int LOCK_W     = 9;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // scans of one key before a short or long status clears itself
    localparam logic [LOCK_W-1:0] LOCK_LIMIT = LOCK_W'(300);

    // register indexes on the config port
    localparam logic [1:0] REG_LONG_PRESS      = 2'd0;
    localparam logic [1:0] REG_KEEP_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd2;

    // register reset values
    localparam logic [TICK_W-1:0] LONG_PRESS_RST      = TICK_W'(1000);
    localparam logic [TICK_W-1:0] KEEP_LONG_PRESS_RST = TICK_W'(5000);
    localparam logic [TICK_W-1:0] REPEAT_INTERVAL_RST = TICK_W'(200);

    // press status codes
    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_SHORT     = 3'd1,
        ST_LONG      = 3'd2,
        ST_KEEP_LONG = 3'd3,
        ST_REPEAT    = 3'd4
    } status_t;

    // threshold registers
    typedef struct packed {
        logic [TICK_W-1:0] long_press_ticks;
        logic [TICK_W-1:0] keep_long_press_ticks;
        logic [TICK_W-1:0] repeat_interval_ticks;
    } cfg_t;

    // tracking state kept for one key
    typedef struct packed {
        logic               was_pressed;
        logic [TICK_W-1:0]  press_start_tick;
        logic [TICK_W-1:0]  repeat_start_tick;
        logic [COUNT_W-1:0] repeat_counter;
        status_t            status_code;
        logic [LOCK_W-1:0]  lock_counter;
    } key_state_t;

    // result of one scan update
    typedef struct packed {
        status_t            press_status;
        logic [COUNT_W-1:0] repeat_count;
    } key_result_t;

endpackage

// File: sv/button_press_classifier.sv
// top level of the button press classifier: scan register, key state, result register
//
//  channel  | handshake                  | word
//  ---------+----------------------------+-------------------------------------------
//  scan     | scan_valid / scan_stall    | key_index, pin_level, tick_now, acknowledge
//  result   | result_valid / result_stall| key_index_out, press_status, repeat_count
//  config   | apb psel/penable/pready    | three 32-bit thresholds at 0x0, 0x4, 0x8
//
//  one scan word per cycle unless scan_stall is high; a taken scan passes through the scan
//  register, then the key update into the result register
//  the per-key state is read and written in the same cycle, so scans of one key
//  may follow each other back to back
//  reset clears all key state and loads the threshold defaults
//  result_stall holds the result; an empty scan register takes one more word,
//  then scan_stall rises
module button_press_classifier #(
    parameter int NUM_KEYS = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // config port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bpc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [bpc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    // scan channel
    input  logic                             scan_valid,
    output logic                             scan_stall,
    input  logic                             key_index,
    input  logic                             pin_level,
    input  logic [bpc_pkg::TICK_W-1:0]       tick_now,
    input  logic                             acknowledge,
    // result channel
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic                             key_index_out,
    output logic [2:0]                       press_status,
    output logic [bpc_pkg::COUNT_W-1:0]      repeat_count
);
    import bpc_pkg::*;

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    cfg_t              cfg;

    // scan register
    logic              scan_valid_reg;
    logic              scan_key_reg;
    logic              scan_pressed_reg;
    logic [TICK_W-1:0] scan_tick_reg;
    logic              scan_ack_reg;

    // result register
    logic               result_valid_reg;
    logic               result_key_reg;
    status_t            result_status_reg;
    logic [COUNT_W-1:0] result_count_reg;

    // key state
    key_state_t         key_state_reg [NUM_KEYS];
    key_state_t         key_state_next;
    key_state_t         cur_state;
    key_result_t        upd_res;
    logic [KEY_W-1:0]   key_sel;
    logic               key_hit;
    logic               advance;

    bpc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake
    assign advance    = !result_valid_reg || !result_stall;
    assign scan_stall = scan_valid_reg && !advance;

    // scan register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_valid_reg <= 1'b0;
        else if (!scan_stall)
            scan_valid_reg <= scan_valid;
    end

    always_ff @(posedge clk)
    begin
        if (scan_valid && !scan_stall)
        begin
            scan_key_reg     <= key_index;
            scan_pressed_reg <= !pin_level;
            scan_tick_reg    <= tick_now;
            scan_ack_reg     <= acknowledge;
        end
    end

    // key selection
    assign key_sel   = KEY_W'(scan_key_reg);
    assign key_hit   = (32'(scan_key_reg) < NUM_KEYS);
    assign cur_state = key_state_reg[key_sel];

    bpc_key_update u_update (
        .cfg     (cfg),
        .cur     (cur_state),
        .pressed (scan_pressed_reg),
        .tick    (scan_tick_reg),
        .ack     (scan_ack_reg),
        .nxt     (key_state_next),
        .res     (upd_res)
    );

    // key state write back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                key_state_reg[i] <= '{
                    was_pressed:       1'b0,
                    press_start_tick:  '0,
                    repeat_start_tick: '0,
                    repeat_counter:    '0,
                    status_code:       ST_NONE,
                    lock_counter:      '0
                };
            end
        end
        else if (scan_valid_reg && advance && key_hit)
        begin
            key_state_reg[key_sel] <= key_state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= scan_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (scan_valid_reg && advance)
        begin
            result_key_reg <= scan_key_reg;
            if (key_hit)
            begin
                result_status_reg <= upd_res.press_status;
                result_count_reg  <= upd_res.repeat_count;
            end
            else
            begin
                result_status_reg <= ST_NONE;
                result_count_reg  <= '0;
            end
        end
    end

    assign result_valid  = result_valid_reg;
    assign key_index_out = result_key_reg;
    assign press_status  = result_status_reg;
    assign repeat_count  = result_count_reg;

endmodule

// File: sv/bpc_cfg.sv
// apb register file holding the press thresholds
module bpc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bpc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [bpc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output bpc_pkg::cfg_t                    cfg
);
    import bpc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks      <= LONG_PRESS_RST;
            cfg_reg.keep_long_press_ticks <= KEEP_LONG_PRESS_RST;
            cfg_reg.repeat_interval_ticks <= REPEAT_INTERVAL_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_LONG_PRESS:      cfg_reg.long_press_ticks      <= pwdata;
                REG_KEEP_LONG_PRESS: cfg_reg.keep_long_press_ticks <= pwdata;
                REG_REPEAT_INTERVAL: cfg_reg.repeat_interval_ticks <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_LONG_PRESS:      prdata = cfg_reg.long_press_ticks;
            REG_KEEP_LONG_PRESS: prdata = cfg_reg.keep_long_press_ticks;
            REG_REPEAT_INTERVAL: prdata = cfg_reg.repeat_interval_ticks;
            default:             prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/bpc_key_update.sv
// next state and reported status of one key for one scan word
module bpc_key_update (
    input  bpc_pkg::cfg_t                    cfg,
    input  bpc_pkg::key_state_t              cur,
    input  logic                             pressed,
    input  logic [bpc_pkg::TICK_W-1:0]       tick,
    input  logic                             ack,
    output bpc_pkg::key_state_t              nxt,
    output bpc_pkg::key_result_t             res
);
    import bpc_pkg::*;

    logic [TICK_W-1:0] held;
    logic [TICK_W-1:0] since_repeat;
    logic              past_keep_long;
    logic              past_long;
    logic              repeat_due;
    key_state_t        mid;
    logic [LOCK_W-1:0] lock_inc;

    // hold and repeat intervals, modulo 2^32
    assign held           = tick - cur.press_start_tick;
    assign since_repeat   = tick - cur.repeat_start_tick;
    assign past_keep_long = held > cfg.keep_long_press_ticks;
    assign past_long      = held > cfg.long_press_ticks;
    assign repeat_due     = since_repeat > cfg.repeat_interval_ticks;

    always_comb
    begin
        mid = cur;
        // press edge, repeat while held, classify on release
        if (pressed)
        begin
            if (!cur.was_pressed)
            begin
                mid.press_start_tick  = tick;
                mid.repeat_start_tick = tick;
                mid.repeat_counter    = '0;
            end
            else if (!past_keep_long && repeat_due)
            begin
                mid.repeat_start_tick = tick;
                mid.status_code       = ST_REPEAT;
                mid.repeat_counter    = cur.repeat_counter + COUNT_W'(1);
            end
        end
        else if (cur.was_pressed)
        begin
            if (past_keep_long)
                mid.status_code = ST_KEEP_LONG;
            else if (past_long)
                mid.status_code = ST_LONG;
            else
                mid.status_code = ST_SHORT;
            mid.lock_counter = '0;
        end
        mid.was_pressed = pressed;
        lock_inc        = mid.lock_counter + LOCK_W'(1);

        // short and long clear themselves after the lock period
        nxt = mid;
        if (mid.status_code inside {ST_SHORT, ST_LONG})
        begin
            if (lock_inc >= LOCK_LIMIT)
            begin
                nxt.status_code  = ST_NONE;
                nxt.lock_counter = '0;
            end
            else
            begin
                nxt.lock_counter = lock_inc;
            end
        end

        res.press_status = nxt.status_code;
        res.repeat_count = nxt.repeat_counter;

        // acknowledge drops a short status after it has been reported
        if (ack && nxt.status_code == ST_SHORT)
            nxt.status_code = ST_NONE;
    end

endmodule

// File: sim/tb_button_press_classifier.sv
// self-checking testbench for the button press classifier
`timescale 1ns / 1ps

module tb_button_press_classifier;
    import bpc_pkg::*;

    // register index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;
    // cycles with no handshake before the run is called hung
    localparam int QUIET_LIMIT = 2000;

    // one expected result word
    typedef struct {
        bit                 key;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } press_word_t;

    // tracks key state and thresholds, and holds the expected result words
    class press_scoreboard;
        logic [TICK_W-1:0]  long_ticks;
        logic [TICK_W-1:0]  keep_ticks;
        logic [TICK_W-1:0]  interval_ticks;
        bit                 held[2];
        logic [TICK_W-1:0]  press_tick[2];
        logic [TICK_W-1:0]  last_repeat_tick[2];
        logic [COUNT_W-1:0] repeats[2];
        status_t            status[2];
        logic [LOCK_W-1:0]  lock_cnt[2];
        press_word_t        pending_status[$];
        int                 fail_count;

        function new();
            long_ticks     = LONG_PRESS_RST;
            keep_ticks     = KEEP_LONG_PRESS_RST;
            interval_ticks = REPEAT_INTERVAL_RST;
            fail_count     = 0;
            foreach (held[i])
            begin
                held[i]             = 1'b0;
                press_tick[i]       = '0;
                last_repeat_tick[i] = '0;
                repeats[i]          = '0;
                status[i]           = ST_NONE;
                lock_cnt[i]         = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [TICK_W-1:0] val);
            case (idx)
                REG_LONG_PRESS:      long_ticks = val;
                REG_KEEP_LONG_PRESS: keep_ticks = val;
                REG_REPEAT_INTERVAL: interval_ticks = val;
                default: ;
            endcase
        endfunction

        function logic [TICK_W-1:0] read_reg(logic [1:0] idx);
            case (idx)
                REG_LONG_PRESS:      return long_ticks;
                REG_KEEP_LONG_PRESS: return keep_ticks;
                default:             return interval_ticks;
            endcase
        endfunction

        // update one key from an accepted scan word and queue its result
        function void classify_scan(bit k, bit pin, logic [TICK_W-1:0] now, bit ack);
            logic [TICK_W-1:0] held_for;
            logic [TICK_W-1:0] since_repeat;
            press_word_t       w;
            held_for     = now - press_tick[k];
            since_repeat = now - last_repeat_tick[k];
            if (!pin)
            begin
                // new press, or repeat while held up to the keep-long limit
                if (!held[k])
                begin
                    press_tick[k]       = now;
                    last_repeat_tick[k] = now;
                    repeats[k]          = '0;
                end
                else if (held_for <= keep_ticks && since_repeat > interval_ticks)
                begin
                    last_repeat_tick[k] = now;
                    status[k]           = ST_REPEAT;
                    repeats[k]          = repeats[k] + 1'b1;
                end
            end
            else if (held[k])
            begin
                // release: classify by held duration
                if (held_for > keep_ticks)
                    status[k] = ST_KEEP_LONG;
                else if (held_for > long_ticks)
                    status[k] = ST_LONG;
                else
                    status[k] = ST_SHORT;
                lock_cnt[k] = '0;
            end
            held[k] = !pin;

            // short and long clear themselves after enough scans
            if (status[k] == ST_LONG || status[k] == ST_SHORT)
            begin
                lock_cnt[k] = lock_cnt[k] + 1'b1;
                if (lock_cnt[k] >= LOCK_LIMIT)
                begin
                    status[k]   = ST_NONE;
                    lock_cnt[k] = '0;
                end
            end

            w.key    = k;
            w.status = status[k];
            w.count  = repeats[k];
            pending_status.push_back(w);

            // acknowledge clears a short status after it is reported
            if (ack && status[k] == ST_SHORT)
                status[k] = ST_NONE;
        endfunction

        function void check_result(bit k, logic [2:0] st, logic [COUNT_W-1:0] cnt);
            press_word_t w;
            if (pending_status.size() == 0)
            begin
                $display("%0t: result word with none expected, key %0d status %0d count %0d",
                         $time, k, st, cnt);
                fail_count++;
                return;
            end
            w = pending_status.pop_front();
            if (k !== w.key)
            begin
                $display("%0t: key_index_out expected %0d actual %0d", $time, w.key, k);
                fail_count++;
            end
            if (st !== w.status)
            begin
                $display("%0t: press_status expected %0d actual %0d", $time, w.status, st);
                fail_count++;
            end
            if (cnt !== w.count)
            begin
                $display("%0t: repeat_count expected %0d actual %0d", $time, w.count, cnt);
                fail_count++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  scan_valid = 1'b0;
    logic                  scan_stall;
    logic                  key_index = 1'b0;
    logic                  pin_level = 1'b1;
    logic [TICK_W-1:0]     tick_now = '0;
    logic                  acknowledge = 1'b0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic                  key_index_out;
    logic [2:0]            press_status;
    logic [COUNT_W-1:0]    repeat_count;

    press_scoreboard   book = new();
    bit                idle_on = 1'b0;
    int                stall_left = 0;
    int                quiet_cycles = 0;
    logic [TICK_W-1:0] key_tick[2];
    bit                key_down[2];
    int                scans_left[2];
    int                ack_rate[2];

    button_press_classifier #(
        .NUM_KEYS(2)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .scan_valid   (scan_valid),
        .scan_stall   (scan_stall),
        .key_index    (key_index),
        .pin_level    (pin_level),
        .tick_now     (tick_now),
        .acknowledge  (acknowledge),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .key_index_out(key_index_out),
        .press_status (press_status),
        .repeat_count (repeat_count)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side stalls in bursts of random length, started only while idle_on is set
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left   <= $urandom_range(0, 16);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            book.check_result(key_index_out, press_status, repeat_count);
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || psel || (scan_valid && !scan_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // send one scan word, with an optional gap before it
    task automatic send_scan(bit k, bit pin, logic [TICK_W-1:0] t, bit ack);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            scan_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        scan_valid  <= 1'b1;
        key_index   <= k;
        pin_level   <= pin;
        tick_now    <= t;
        acknowledge <= ack;
        do
            @(posedge clk);
        while (scan_stall);
        book.classify_scan(k, pin, t, ack);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        book.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_check(logic [1:0] idx);
        logic [CFG_DATA_W-1:0] want;
        want    = book.read_reg(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $display("%0t: register %0d read expected %0h actual %0h", $time, idx, want, prdata);
            book.fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_thresholds(logic [TICK_W-1:0] lt, logic [TICK_W-1:0] kt,
                                  logic [TICK_W-1:0] rt);
        apb_write(REG_LONG_PRESS, lt);
        apb_write(REG_KEEP_LONG_PRESS, kt);
        apb_write(REG_REPEAT_INTERVAL, rt);
        apb_check(REG_LONG_PRESS);
        apb_check(REG_KEEP_LONG_PRESS);
        apb_check(REG_REPEAT_INTERVAL);
    endtask

    // stop sending and wait until every result word is back
    task automatic drain_results();
        scan_valid <= 1'b0;
        while (book.pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // press and release episodes per key with random tick steps, plus noise words
    task automatic run_scan_traffic(int n_items, int max_step, bit allow_idle);
        bit                k;
        bit                pin;
        bit                ack;
        logic [TICK_W-1:0] t;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 64 == 0)
                idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            k = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 11) == 0)
            begin
                pin = 1'($urandom_range(0, 1));
                t   = $urandom;
                ack = 1'($urandom_range(0, 1));
            end
            else
            begin
                if (scans_left[k] == 0)
                begin
                    key_down[k] = !key_down[k];
                    ack_rate[k] = ($urandom_range(0, 1) == 0) ? 0 : 4;
                    if (key_down[k])
                        scans_left[k] = $urandom_range(1, 40);
                    else if ($urandom_range(0, 3) == 0)
                        scans_left[k] = $urandom_range(300, 310);
                    else
                        scans_left[k] = $urandom_range(1, 20);
                end
                scans_left[k]--;
                key_tick[k] = key_tick[k] + $urandom_range(0, max_step);
                pin = !key_down[k];
                t   = key_tick[k];
                ack = (ack_rate[k] != 0) && ($urandom_range(1, ack_rate[k]) == 1);
            end
            send_scan(k, pin, t, ack);
        end
    endtask

    initial
    begin
        logic [TICK_W-1:0] lt;

        foreach (key_tick[i])
        begin
            key_tick[i]   = $urandom;
            key_down[i]   = 1'b0;
            scans_left[i] = 0;
            ack_rate[i]   = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at the default thresholds
        idle_on = 1'b1;
        send_scan(1'b0, 1'b1, 32'h0000_0000, 1'b0);
        send_scan(1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
        // repeat across tick wrap, then long press
        send_scan(1'b0, 1'b0, 32'hFFFF_FF00, 1'b0);
        send_scan(1'b0, 1'b0, 32'h0000_00FA, 1'b0);
        send_scan(1'b0, 1'b0, 32'h0000_00FB, 1'b1);
        send_scan(1'b0, 1'b1, 32'h0000_053C, 1'b0);
        send_scan(1'b0, 1'b1, 32'h0000_0540, 1'b1);
        // short press cleared by acknowledge
        send_scan(1'b1, 1'b0, 32'd16, 1'b0);
        send_scan(1'b1, 1'b1, 32'd32, 1'b1);
        send_scan(1'b1, 1'b1, 32'd48, 1'b0);
        // repeat, hold past keep-long, then keep-long release
        send_scan(1'b1, 1'b0, 32'd100, 1'b0);
        send_scan(1'b1, 1'b0, 32'd301, 1'b0);
        send_scan(1'b1, 1'b0, 32'd5101, 1'b0);
        send_scan(1'b1, 1'b1, 32'd5102, 1'b0);
        send_scan(1'b1, 1'b1, 32'd5103, 1'b1);
        // held exactly at the long limit stays short
        send_scan(1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0);
        send_scan(1'b0, 1'b1, 32'd999, 1'b0);
        // repeat interval boundary, then long
        send_scan(1'b0, 1'b0, 32'd1000, 1'b0);
        send_scan(1'b0, 1'b0, 32'd1200, 1'b0);
        send_scan(1'b0, 1'b0, 32'd1201, 1'b0);
        send_scan(1'b0, 1'b1, 32'd2001, 1'b0);
        // held exactly at the keep-long limit is long
        send_scan(1'b1, 1'b0, 32'd0, 1'b0);
        send_scan(1'b1, 1'b1, 32'd5000, 1'b0);
        send_scan(1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1);

        // small thresholds so every class shows up, write to the unused slot too
        drain_results();
        set_thresholds(32'd40, 32'd160, 32'd8);
        apb_write(REG_UNUSED, $urandom);
        apb_check(REG_LONG_PRESS);
        apb_check(REG_KEEP_LONG_PRESS);
        apb_check(REG_REPEAT_INTERVAL);
        key_tick[0] = 32'hFFFF_FF80;
        run_scan_traffic(800, 12, 1'b1);

        // zero limits, no keep-long: every nonzero tick step repeats
        drain_results();
        set_thresholds(32'd0, 32'hFFFF_FFFF, 32'd0);
        run_scan_traffic(300, 3, 1'b1);

        // top limits, zero keep-long
        drain_results();
        set_thresholds(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        run_scan_traffic(300, 5, 1'b1);

        // random mid settings, no idling to the end
        drain_results();
        lt = $urandom_range(5, 60);
        set_thresholds(lt, lt + $urandom_range(0, 150), $urandom_range(0, 20));
        run_scan_traffic(500, 10, 1'b0);
        idle_on = 1'b0;

        // wait for the last result words
        scan_valid <= 1'b0;
        while (book.pending_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (book.fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
sv/bpc_pkg.sv
sv/bpc_cfg.sv
sv/bpc_key_update.sv
sv/button_press_classifier.sv
sim/tb_button_press_classifier.sv
